/* src/complex_arithmetic_unit_macros.svh */
// ---------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Implication checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/cau_pkg.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, status codes and the decoded operation kind.
// ---------------------------------------------------------------------------
package cau_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;
	localparam logic [1:0] ST_UNUSED  = 2'd3;

	localparam int KIND_BITS = 3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ADD,
		KIND_SUB,
		KIND_MUL,
		KIND_DIV,
		KIND_REM,
		KIND_NONE
	} kind_t;

endpackage

/* src/complex_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and componentwise remainder on signed
// fixed-point complex operands, with saturation and divide-by-zero status.
// ---------------------------------------------------------------------------
// One transaction is accepted per clock while the queue has room, and one
// result leaves per clock once the pipeline is full and the result port does
// not stall. Every operation takes the same path: input register, a
// four-entry queue, an operand register, three arithmetic stages (products,
// sums, operand setup), WORD_BITS restoring-division stages that each resolve
// one quotient bit, and the output register. A stall at the result port holds
// the whole execution pipeline while the queue keeps taking input.
module complex_arithmetic_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        stall,
	input  logic [2:0]                  op,
	input  logic signed [WORD_BITS-1:0] x_re,
	input  logic signed [WORD_BITS-1:0] x_im,
	input  logic signed [WORD_BITS-1:0] y_re,
	input  logic signed [WORD_BITS-1:0] y_im,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic signed [WORD_BITS-1:0] res_re,
	output logic signed [WORD_BITS-1:0] res_im,
	output logic [1:0]                  status
);
	import cau_pkg::*;

	`include "complex_arithmetic_unit_macros.svh"

	localparam int QW     = KIND_BITS + 4 * WORD_BITS;
	localparam int QDEPTH = 4;
	localparam logic signed [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic                        q_push, q_full, q_pop, q_empty;
	kind_t                       f_kind;
	logic signed [WORD_BITS-1:0] f_xr, f_xi, f_yr, f_yi;
	logic [QW-1:0]               q_din, q_dout;
	kind_t                       b_kind;
	logic signed [WORD_BITS-1:0] b_xr, b_xi, b_yr, b_yi;

	cau_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid),
		.stall  (stall),
		.op     (op),
		.x_re   (x_re),
		.x_im   (x_im),
		.y_re   (y_re),
		.y_im   (y_im),
		.q_push (q_push),
		.q_full (q_full),
		.kind   (f_kind),
		.xr     (f_xr),
		.xi     (f_xi),
		.yr     (f_yr),
		.yi     (f_yi)
	);

	assign q_din = {f_kind, f_xr, f_xi, f_yr, f_yi};

	cau_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_kind = kind_t'(q_dout[QW-1 -: KIND_BITS]);
	assign b_xr   = q_dout[4*WORD_BITS-1 -: WORD_BITS];
	assign b_xi   = q_dout[3*WORD_BITS-1 -: WORD_BITS];
	assign b_yr   = q_dout[2*WORD_BITS-1 -: WORD_BITS];
	assign b_yi   = q_dout[WORD_BITS-1:0];

	cau_back #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_v    (!q_empty),
		.pop       (q_pop),
		.kind      (b_kind),
		.xr        (b_xr),
		.xi        (b_xi),
		.yr        (b_yr),
		.yi        (b_yi),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_re    (res_re),
		.res_im    (res_im),
		.status    (status)
	);

	`CAU_ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")
	`CAU_ASSERT_IMPLY(a_push_room, clk, arst_n, q_push, !q_full, "push into full queue")
	`CAU_ASSERT_IMPLY(a_status_code, clk, arst_n, res_valid, status != ST_UNUSED, "bad status")
	`CAU_ASSERT_IMPLY(a_sat_clamped, clk, arst_n, res_valid && status == ST_SAT, res_re == SMAX || res_re == SMIN || res_im == SMAX || res_im == SMIN, "saturation without clamp")
	`CAU_ASSERT_NEXT(a_stall_full, clk, arst_n, stall && !q_pop, q_full, "stall without full queue")

endmodule

/* src/cau_front.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accepts transactions, decodes the opcode and pushes into the queue.
// ---------------------------------------------------------------------------
module cau_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        stall,
	input  logic [2:0]                  op,
	input  logic signed [WORD_BITS-1:0] x_re,
	input  logic signed [WORD_BITS-1:0] x_im,
	input  logic signed [WORD_BITS-1:0] y_re,
	input  logic signed [WORD_BITS-1:0] y_im,
	output logic                        q_push,
	input  logic                        q_full,
	output cau_pkg::kind_t              kind,
	output logic signed [WORD_BITS-1:0] xr,
	output logic signed [WORD_BITS-1:0] xi,
	output logic signed [WORD_BITS-1:0] yr,
	output logic signed [WORD_BITS-1:0] yi
);
	import cau_pkg::*;

	logic                        v_s1;
	kind_t                       k_s1;
	logic signed [WORD_BITS-1:0] xr_s1, xi_s1, yr_s1, yi_s1;
	kind_t                       k_dec;
	logic                        load;

	always_comb begin
		unique case (op)
			OP_ADD:  k_dec = KIND_ADD;
			OP_SUB:  k_dec = KIND_SUB;
			OP_MUL:  k_dec = KIND_MUL;
			OP_DIV:  k_dec = KIND_DIV;
			OP_REM:  k_dec = KIND_REM;
			default: k_dec = KIND_NONE;
		endcase
	end

	assign stall  = v_s1 && q_full;
	assign load   = valid && !stall;
	assign q_push = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			k_s1  <= k_dec;
			xr_s1 <= x_re;
			xi_s1 <= x_im;
			yr_s1 <= y_re;
			yi_s1 <= y_im;
		end
	end

	assign kind = k_s1;
	assign xr   = xr_s1;
	assign xi   = xi_s1;
	assign yr   = yr_s1;
	assign yi   = yi_s1;

endmodule

/* src/cau_queue.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit queue
// Short register FIFO between front end and execution pipeline.
// ---------------------------------------------------------------------------
module cau_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PB = $clog2(DEPTH);
	localparam int CB = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PB-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CB-1:0]    count_q;

	assign full  = count_q == CB'(DEPTH);
	assign empty = count_q == '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* src/cau_back.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit execution pipeline
// Products, sums, one restoring quotient bit per stage, output register.
// ---------------------------------------------------------------------------
module cau_back #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_v,
	output logic                        pop,
	input  cau_pkg::kind_t              kind,
	input  logic signed [WORD_BITS-1:0] xr,
	input  logic signed [WORD_BITS-1:0] xi,
	input  logic signed [WORD_BITS-1:0] yr,
	input  logic signed [WORD_BITS-1:0] yi,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic signed [WORD_BITS-1:0] res_re,
	output logic signed [WORD_BITS-1:0] res_im,
	output logic [1:0]                  status
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * WORD_BITS;
	localparam int NW = 2 * WORD_BITS + FRAC_BITS;
	localparam logic signed [W-1:0]    SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]    SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [PW+1:0]   SMAX_X = (PW+2)'(SMAX);
	localparam logic signed [PW+1:0]   SMIN_X = (PW+2)'(SMIN);
	localparam logic [W-1:0]           LIM_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]           LIM_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [PW+1:0]   BIAS = (PW+2)'((65'd1 << FRAC_BITS) - 65'd1);

	typedef struct packed {
		logic [PW-1:0] a;
		logic [W-1:0]  b;
		logic [PW-1:0] d;
		logic          neg;
		logic          ovf;
		logic          dz;
	} lane_t;

	typedef struct packed {
		kind_t         k;
		logic [W-1:0]  dre;
		logic [W-1:0]  dim;
		logic          dsat;
		lane_t         lr;
		lane_t         li;
	} stage_t;

	function automatic lane_t div_lane(input logic signed [PW:0] num,
		input logic [PW-1:0] den);
		lane_t         l;
		logic [PW:0]   m;
		logic [NW-1:0] n;
		logic [NW-1:0] r0;
		m = num[PW] ? (~num + 1'b1) : num;
		n = NW'(m[PW-1:0]) << FRAC_BITS;
		r0 = n >> W;
		l.neg = num[PW];
		l.ovf = r0 >= NW'(den);
		l.a = l.ovf ? '0 : r0[PW-1:0];
		l.b = n[W-1:0];
		l.d = den;
		l.dz = den == '0;
		return l;
	endfunction

	function automatic lane_t rem_lane(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y);
		lane_t        l;
		logic [W-1:0] mx, my;
		mx = x[W-1] ? (~x + 1'b1) : x;
		my = y[W-1] ? (~y + 1'b1) : y;
		l.neg = x[W-1];
		l.ovf = 1'b0;
		l.a = '0;
		l.b = mx;
		l.d = PW'(my);
		l.dz = my == '0;
		return l;
	endfunction

	function automatic lane_t div_step(input lane_t l);
		lane_t       o;
		logic [PW:0] t;
		logic        ge;
		t = {l.a, l.b[W-1]};
		ge = t >= {1'b0, l.d};
		o = l;
		o.a = ge ? PW'(t - {1'b0, l.d}) : t[PW-1:0];
		o.b = {l.b[W-2:0], ge};
		return o;
	endfunction

	function automatic logic [W:0] clamp(input logic signed [PW+1:0] v);
		if (v > SMAX_X) begin
			return {1'b1, SMAX};
		end else if (v < SMIN_X) begin
			return {1'b1, SMIN};
		end
		return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic [W:0] quo_out(input lane_t l);
		logic [W-1:0] lim, m;
		logic         sat;
		lim = l.neg ? LIM_NEG : LIM_POS;
		sat = l.ovf || (l.b > lim);
		m = sat ? lim : l.b;
		return {sat, l.neg ? (~m + 1'b1) : m};
	endfunction

	function automatic logic [W-1:0] rem_out(input lane_t l);
		logic [W-1:0] r;
		r = l.a[W-1:0];
		if (l.dz) begin
			return '0;
		end
		return l.neg ? (~r + 1'b1) : r;
	endfunction

	logic                         en;
	logic                         v_s1, v_s2, v_s3;
	kind_t                        k_s1, k_s2, k_s3;
	logic signed [W-1:0]          xr_s1, xi_s1, yr_s1, yi_s1;
	logic signed [W-1:0]          xr_s2, xi_s2, yr_s2, yi_s2;
	logic signed [W-1:0]          xr_s3, xi_s3, yr_s3, yi_s3;
	logic signed [PW-1:0]         prr_s2, pii_s2, pri_s2, pir_s2, drr_s2, dii_s2;
	logic signed [W:0]            sre_s2, sim_s2, sre_s3, sim_s3;
	logic signed [PW:0]           cre_s3, cim_s3;
	logic [PW-1:0]                den_s3;
	logic                         pv_s [W+1];
	stage_t                       pd_s [W+1];
	stage_t                       st0;
	logic signed [PW+1:0]         tre, tim, vre, vim;
	logic [W:0]                   cre_c, cim_c, qre, qim;
	logic                         res_valid_q;
	logic [W-1:0]                 re_q, im_q;
	logic [1:0]                   status_q;
	logic [W-1:0]                 fre, fim;
	logic [1:0]                   fst;

	assign en  = !res_valid_q || !res_stall;
	assign pop = head_v && en;

	always_comb begin
		tre = $signed((PW+2)'(cre_s3) + (cre_s3[PW] ? BIAS : '0)) >>> FRAC_BITS;
		tim = $signed((PW+2)'(cim_s3) + (cim_s3[PW] ? BIAS : '0)) >>> FRAC_BITS;
		vre = (k_s3 == KIND_MUL) ? tre : (PW+2)'(sre_s3);
		vim = (k_s3 == KIND_MUL) ? tim : (PW+2)'(sim_s3);
		cre_c = clamp(vre);
		cim_c = clamp(vim);
		st0.k = k_s3;
		st0.dre = cre_c[W-1:0];
		st0.dim = cim_c[W-1:0];
		st0.dsat = cre_c[W] || cim_c[W];
		if (k_s3 == KIND_REM) begin
			st0.lr = rem_lane(xr_s3, yr_s3);
			st0.li = rem_lane(xi_s3, yi_s3);
		end else begin
			st0.lr = div_lane(cre_s3, den_s3);
			st0.li = div_lane(cim_s3, den_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int j = 0; j <= W; j++) begin
				pv_s[j] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			pv_s[0] <= v_s3;
			for (int j = 0; j < W; j++) begin
				pv_s[j+1] <= pv_s[j];
			end
			res_valid_q <= pv_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1  <= kind;
			xr_s1 <= xr;
			xi_s1 <= xi;
			yr_s1 <= yr;
			yi_s1 <= yi;

			k_s2   <= k_s1;
			prr_s2 <= PW'(xr_s1) * PW'(yr_s1);
			pii_s2 <= PW'(xi_s1) * PW'(yi_s1);
			pri_s2 <= PW'(xr_s1) * PW'(yi_s1);
			pir_s2 <= PW'(xi_s1) * PW'(yr_s1);
			drr_s2 <= PW'(yr_s1) * PW'(yr_s1);
			dii_s2 <= PW'(yi_s1) * PW'(yi_s1);
			sre_s2 <= (k_s1 == KIND_SUB) ? (W+1)'(xr_s1) - (W+1)'(yr_s1)
				: (W+1)'(xr_s1) + (W+1)'(yr_s1);
			sim_s2 <= (k_s1 == KIND_SUB) ? (W+1)'(xi_s1) - (W+1)'(yi_s1)
				: (W+1)'(xi_s1) + (W+1)'(yi_s1);
			xr_s2 <= xr_s1;
			xi_s2 <= xi_s1;
			yr_s2 <= yr_s1;
			yi_s2 <= yi_s1;

			k_s3   <= k_s2;
			cre_s3 <= (k_s2 == KIND_MUL) ? (PW+1)'(prr_s2) - (PW+1)'(pii_s2)
				: (PW+1)'(prr_s2) + (PW+1)'(pii_s2);
			cim_s3 <= (k_s2 == KIND_MUL) ? (PW+1)'(pri_s2) + (PW+1)'(pir_s2)
				: (PW+1)'(pir_s2) - (PW+1)'(pri_s2);
			den_s3 <= $unsigned(drr_s2) + $unsigned(dii_s2);
			sre_s3 <= sre_s2;
			sim_s3 <= sim_s2;
			xr_s3  <= xr_s2;
			xi_s3  <= xi_s2;
			yr_s3  <= yr_s2;
			yi_s3  <= yi_s2;

			pd_s[0] <= st0;
			for (int j = 0; j < W; j++) begin
				pd_s[j+1].k    <= pd_s[j].k;
				pd_s[j+1].dre  <= pd_s[j].dre;
				pd_s[j+1].dim  <= pd_s[j].dim;
				pd_s[j+1].dsat <= pd_s[j].dsat;
				pd_s[j+1].lr   <= div_step(pd_s[j].lr);
				pd_s[j+1].li   <= div_step(pd_s[j].li);
			end

			re_q     <= fre;
			im_q     <= fim;
			status_q <= fst;
		end
	end

	always_comb begin
		qre = quo_out(pd_s[W].lr);
		qim = quo_out(pd_s[W].li);
		fre = '0;
		fim = '0;
		fst = ST_OK;
		case (pd_s[W].k) inside
			KIND_ADD, KIND_SUB, KIND_MUL: begin
				fre = pd_s[W].dre;
				fim = pd_s[W].dim;
				fst = pd_s[W].dsat ? ST_SAT : ST_OK;
			end
			KIND_DIV: begin
				if (pd_s[W].lr.dz) begin
					fst = ST_DIVZERO;
				end else begin
					fre = qre[W-1:0];
					fim = qim[W-1:0];
					fst = (qre[W] || qim[W]) ? ST_SAT : ST_OK;
				end
			end
			KIND_REM: begin
				fre = rem_out(pd_s[W].lr);
				fim = rem_out(pd_s[W].li);
				fst = (pd_s[W].lr.dz || pd_s[W].li.dz) ? ST_DIVZERO : ST_OK;
			end
			default: begin
				fst = ST_OK;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_re    = re_q;
	assign res_im    = im_q;
	assign status    = status_q;

endmodule

/* tb/sv/complex_arithmetic_unit_tb.sv */
// ---------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed corner rows and random operand sets through the valid/stall
// ports and checks every result against the row's expected value or a
// wide-integer predictor. Both ports idle at random, and the result port is
// also held off long enough to back up the pipeline.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int HOLD_CYCLES     = 300;
	localparam int RANDOM_ITEMS    = 1580;
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] W_MIN = 32'sh80000000;
	localparam logic signed [31:0] W_ONE = 32'sh00010000;

	typedef logic signed [159:0] wide_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [1:0]         st;
	} cplx_res_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] xr;
		logic signed [31:0] xi;
		logic signed [31:0] yr;
		logic signed [31:0] yi;
		logic               known;
		cplx_res_t          res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic stall;
	logic [2:0] op = OP_ADD;
	logic signed [31:0] x_re = '0, x_im = '0, y_re = '0, y_im = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [31:0] res_re, res_im;
	logic [1:0] status;

	logic known_now = 1'b0;
	cplx_res_t typed_res = '0;

	cplx_res_t pending_q[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int sat_seen = 0;
	int dz_seen = 0;
	int idle_mode = 0;
	logic pressure_req = 1'b0;
	logic pressure_done = 1'b0;
	int hold_cnt = 0;
	int quiet_cycles = 0;

	complex_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .op(op),
		.x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im),
		.res_valid(res_valid), .res_stall(res_stall),
		.res_re(res_re), .res_im(res_im), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp_word(wide_t v, inout logic sat);
		if (v > wide_t'(W_MAX)) begin
			sat = 1'b1;
			return W_MAX;
		end
		if (v < wide_t'(W_MIN)) begin
			sat = 1'b1;
			return W_MIN;
		end
		return v[31:0];
	endfunction

	function automatic cplx_res_t complex_result(logic [2:0] opc, logic signed [31:0] a_re,
			logic signed [31:0] a_im, logic signed [31:0] b_re, logic signed [31:0] b_im);
		wide_t ar, ai, br, bi, num_re, num_im, den;
		longint rem_re, rem_im;
		logic sat;
		logic dz;
		cplx_res_t r;
		ar = a_re;
		ai = a_im;
		br = b_re;
		bi = b_im;
		sat = 1'b0;
		dz = 1'b0;
		r = '0;
		case (opc) inside
			OP_ADD, OP_SUB: begin
				if (opc == OP_SUB) begin
					br = -br;
					bi = -bi;
				end
				r.re = clamp_word(ar + br, sat);
				r.im = clamp_word(ai + bi, sat);
			end
			OP_MUL: begin
				r.re = clamp_word((ar * br - ai * bi) / 65536, sat);
				r.im = clamp_word((ar * bi + ai * br) / 65536, sat);
			end
			OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					dz = 1'b1;
				end else begin
					num_re = (ar * br + ai * bi) * 65536;
					num_im = (ai * br - ar * bi) * 65536;
					r.re = clamp_word(num_re / den, sat);
					r.im = clamp_word(num_im / den, sat);
				end
			end
			OP_REM: begin
				if (b_re == 0) begin
					dz = 1'b1;
				end else begin
					rem_re = longint'(a_re) % longint'(b_re);
					r.re = rem_re[31:0];
				end
				if (b_im == 0) begin
					dz = 1'b1;
				end else begin
					rem_im = longint'(a_im) % longint'(b_im);
					r.im = rem_im[31:0];
				end
			end
			default: r = '0;
		endcase
		r.st = dz ? ST_DIVZERO : (sat ? ST_SAT : ST_OK);
		return r;
	endfunction

	always @(posedge clk) begin
		cplx_res_t e;
		if (res_valid && !res_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result re=%h im=%h status=%0d", res_re, res_im, status);
				errors++;
			end else begin
				e = pending_q.pop_front();
				checked++;
				if (res_re !== e.re) begin
					$error("res_re expected %h actual %h", e.re, res_re);
					errors++;
				end
				if (res_im !== e.im) begin
					$error("res_im expected %h actual %h", e.im, res_im);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (e.st == ST_SAT) sat_seen++;
				if (e.st == ST_DIVZERO) dz_seen++;
			end
		end
		if (valid && !stall) begin
			sent++;
			if (known_now)
				pending_q.push_back(typed_res);
			else
				pending_q.push_back(complex_result(op, x_re, x_im, y_re, y_im));
		end
		if ((valid && !stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (pressure_req && !pressure_done) begin
			res_stall <= 1'b1;
			hold_cnt++;
			if (hold_cnt >= HOLD_CYCLES) pressure_done <= 1'b1;
		end else begin
			case (idle_mode)
				0: res_stall <= ($urandom_range(0, 99) < 69);
				1: res_stall <= ($urandom_range(0, 99) < 20);
				default: res_stall <= 1'b0;
			endcase
		end
	end

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return W_MAX;
			1: return W_MIN;
			2: return '0;
			3: return W_ONE;
			4: return -W_ONE;
			5: return $signed(32'($urandom_range(0, 15)) - 32'd8);
			6: return $signed($urandom_range(0, 32'h3ffff) - 32'h20000);
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic offer(row_t r);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 20 : ((idle_mode == 1) ? 69 : 0);
		if ($urandom_range(0, 99) < gap_pct) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		valid <= 1'b1;
		op <= r.op;
		x_re <= r.xr;
		x_im <= r.xi;
		y_re <= r.yr;
		y_im <= r.yi;
		known_now <= r.known;
		typed_res <= r.res;
		do @(posedge clk); while (stall);
	endtask

	row_t directed[] = '{
		'{OP_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, ST_OK}},
		'{OP_ADD, W_MAX, W_MAX, W_MAX, 32'sd1, 1'b1, '{W_MAX, W_MAX, ST_SAT}},
		'{OP_ADD, W_MIN, W_MIN, 32'sd1, -32'sd1, 1'b1, '{W_MIN + 1, W_MIN, ST_SAT}},
		'{OP_SUB, W_MIN, W_MAX, 32'sd1, -32'sd1, 1'b1, '{W_MIN, W_MAX, ST_SAT}},
		'{OP_SUB, W_MAX, 32'sd5, W_MAX, 32'sd5, 1'b1, '{32'sd0, 32'sd0, ST_OK}},
		'{OP_MUL, W_ONE, 32'sd0, W_ONE, 32'sd0, 1'b1, '{W_ONE, 32'sd0, ST_OK}},
		'{OP_MUL, 32'sd0, W_ONE, 32'sd0, W_ONE, 1'b1, '{-W_ONE, 32'sd0, ST_OK}},
		'{OP_MUL, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0, '0},
		'{OP_MUL, W_MAX, W_MIN, W_MIN, W_MAX, 1'b0, '0},
		'{OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b0, '0},
		'{OP_DIV, W_MAX, W_MIN, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, ST_DIVZERO}},
		'{OP_DIV, W_ONE, 32'sd0, W_ONE, 32'sd0, 1'b1, '{W_ONE, 32'sd0, ST_OK}},
		'{OP_DIV, W_MAX, W_MAX, 32'sd1, 32'sd0, 1'b1, '{W_MAX, W_MAX, ST_SAT}},
		'{OP_DIV, W_MIN, W_MAX, 32'sd1, 32'sd1, 1'b0, '0},
		'{OP_DIV, -32'sd7, 32'sd3, W_MIN, W_MAX, 1'b0, '0},
		'{OP_REM, 32'sd5, 32'sd7, 32'sd0, 32'sd3, 1'b1, '{32'sd0, 32'sd1, ST_DIVZERO}},
		'{OP_REM, -32'sd7, 32'sd7, 32'sd3, -32'sd3, 1'b1, '{-32'sd1, 32'sd1, ST_OK}},
		'{OP_REM, W_MIN, W_MAX, -32'sd1, W_MIN, 1'b1, '{32'sd0, W_MAX, ST_OK}},
		'{OP_REM, W_MIN, 32'sd9, W_MAX, 32'sd0, 1'b1, '{-32'sd1, 32'sd0, ST_DIVZERO}},
		'{OP_SPARE5, W_MAX, W_MIN, 32'sd3, 32'sd4, 1'b1, '{32'sd0, 32'sd0, ST_OK}},
		'{OP_SPARE6, 32'sd1, 32'sd2, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, ST_OK}},
		'{OP_SPARE7, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1, '{32'sd0, 32'sd0, ST_OK}}
	};

	initial begin
		row_t r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) offer(directed[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) idle_mode = 1;
			if (i == 2 * RANDOM_ITEMS / 3) begin
				idle_mode = 2;
				pressure_req <= 1'b1;
			end
			r = '0;
			r.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			                                    : 3'($urandom_range(0, 4));
			r.xr = pick_word();
			r.xi = pick_word();
			r.yr = pick_word();
			r.yi = pick_word();
			offer(r);
		end
		valid <= 1'b0;
		known_now <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d transactions, %0d results checked (%0d saturated, %0d div-by-zero).",
			sent, checked, sat_seen, dz_seen);
		$display("Idle patterns on both ports plus one %0d-cycle result hold-off.", HOLD_CYCLES);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
